[sv/tlsd_pkg.sv]
// ----------------------------------------------------------------------------
// tlsd_pkg
// Shared types and constants for the tagged length stream demux.
// ----------------------------------------------------------------------------
package tlsd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 2;
  localparam int LEN_W   = 16;
  localparam int PHASE_W = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // parser phases
  localparam phase_t PHASE_TAG    = 2'd0;
  localparam phase_t PHASE_LEN_HI = 2'd1;
  localparam phase_t PHASE_LEN_LO = 2'd2;
  localparam phase_t PHASE_DATA   = 2'd3;

  // channel codes
  localparam chan_t CHAN_ZERO = 2'd0;
  localparam chan_t CHAN_ONE  = 2'd1;
  localparam chan_t CHAN_TWO  = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t REG_TAG_ZERO = 2'd0;
  localparam cfg_idx_t REG_TAG_ONE  = 2'd1;
  localparam cfg_idx_t REG_TAG_TWO  = 2'd2;

  // tag reset values
  localparam byte_t TAG_ZERO_RST = 8'h01;
  localparam byte_t TAG_ONE_RST  = 8'h02;
  localparam byte_t TAG_TWO_RST  = 8'hfe;

endpackage

[sv/tagged_length_stream_demux.sv]
// A payload word shows on the output in the cycle after it is accepted.
// Throughput: one input word per cycle; input stalls only while a result is
// held in the output register and the output side stalls.
// Header and idle words give no result. Synchronous active-high reset clears
// the parser to tag search and restores the tag registers to 0x01/0x02/0xfe.
// ----------------------------------------------------------------------------
// tagged_length_stream_demux
// Parses tag, two length bytes and payload from a byte stream and forwards
// each payload byte with its channel and an end-of-packet mark.
// ----------------------------------------------------------------------------
module tagged_length_stream_demux (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  tlsd_pkg::cfg_idx_t        cfg_index,
  input  tlsd_pkg::byte_t           cfg_data,
  // input words
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tlsd_pkg::byte_t           in_byte,
  // result words
  output logic                      out_valid,
  input  logic                      out_stall,
  output tlsd_pkg::chan_t           out_channel,
  output tlsd_pkg::byte_t           out_byte,
  output logic                      end_of_packet
);

  tlsd_pkg::byte_t  tag_zero;
  tlsd_pkg::byte_t  tag_one;
  tlsd_pkg::byte_t  tag_two;

  tlsd_pkg::phase_t phase, phase_next;
  tlsd_pkg::chan_t  chan, chan_next;
  tlsd_pkg::len_t   remaining, remaining_next;

  logic             in_acc;
  logic             res_valid;
  logic             res_last;
  tlsd_pkg::len_t   len_lo;
  tlsd_pkg::len_t   dec;

  assign cfg_ready = 1'b1;

  // output register full and held back: stop taking words
  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_zero <= tlsd_pkg::TAG_ZERO_RST;
      tag_one  <= tlsd_pkg::TAG_ONE_RST;
      tag_two  <= tlsd_pkg::TAG_TWO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlsd_pkg::REG_TAG_ZERO: tag_zero <= cfg_data;
        tlsd_pkg::REG_TAG_ONE:  tag_one  <= cfg_data;
        tlsd_pkg::REG_TAG_TWO:  tag_two  <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign len_lo = remaining | {{(tlsd_pkg::LEN_W-tlsd_pkg::BYTE_W){1'b0}}, in_byte};
  assign dec    = remaining - tlsd_pkg::LEN_W'(1);

  // parser next state
  always_comb begin
    phase_next     = phase;
    chan_next      = chan;
    remaining_next = remaining;
    res_valid      = 1'b0;
    res_last       = 1'b0;
    unique case (phase)
      tlsd_pkg::PHASE_TAG: begin
        remaining_next = '0;
        priority if (in_byte == tag_zero) begin
          chan_next  = tlsd_pkg::CHAN_ZERO;
          phase_next = tlsd_pkg::PHASE_LEN_HI;
        end else if (in_byte == tag_one) begin
          chan_next  = tlsd_pkg::CHAN_ONE;
          phase_next = tlsd_pkg::PHASE_LEN_HI;
        end else if (in_byte == tag_two) begin
          chan_next  = tlsd_pkg::CHAN_TWO;
          phase_next = tlsd_pkg::PHASE_LEN_HI;
        end else begin
          phase_next = tlsd_pkg::PHASE_TAG;
        end
      end
      tlsd_pkg::PHASE_LEN_HI: begin
        remaining_next = {in_byte, {tlsd_pkg::BYTE_W{1'b0}}};
        phase_next     = tlsd_pkg::PHASE_LEN_LO;
      end
      tlsd_pkg::PHASE_LEN_LO: begin
        remaining_next = len_lo;
        // empty packet goes straight back to tag search
        phase_next     = (len_lo == '0) ? tlsd_pkg::PHASE_TAG : tlsd_pkg::PHASE_DATA;
      end
      tlsd_pkg::PHASE_DATA: begin
        remaining_next = dec;
        res_valid      = 1'b1;
        res_last       = (dec == '0);
        if (dec == '0) begin
          phase_next = tlsd_pkg::PHASE_TAG;
        end
      end
      default: ;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tlsd_pkg::PHASE_TAG;
      chan      <= tlsd_pkg::CHAN_ZERO;
      remaining <= '0;
    end else if (in_acc) begin
      phase     <= phase_next;
      chan      <= chan_next;
      remaining <= remaining_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_acc & res_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_acc && res_valid) begin
      out_channel   <= chan;
      out_byte      <= in_byte;
      end_of_packet <= res_last;
    end
  end

`ifndef NO_ASSERTIONS
  // payload phase never runs with nothing left to send
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == tlsd_pkg::PHASE_DATA |-> remaining != '0)
    else $error("payload phase with zero remaining");

  // final payload word returns the parser to tag search
  a_last_to_tag: assert property (@(posedge clk) disable iff (rst)
    in_acc && phase == tlsd_pkg::PHASE_DATA && remaining == tlsd_pkg::LEN_W'(1)
    |=> phase == tlsd_pkg::PHASE_TAG && out_valid && end_of_packet)
    else $error("last payload word not closed");

  // a held result blocks input
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // results carry a real channel
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_channel != 2'd3)
    else $error("bad output channel");
`endif

endmodule

[tb/tagged_length_stream_demux_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_length_stream_demux_tb
// Drives tagged, length-prefixed packets and idle noise into the demux and
// compares every forwarded payload word with an in-bench parser model.
// Tag registers are rewritten between phases, including the extremes and
// matching tags. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tagged_length_stream_demux_tb;

  // index with no register behind it; writes to it must be dropped
  localparam tlsd_pkg::cfg_idx_t REG_UNUSED = 2'd3;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_WORDS = 250;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    tlsd_pkg::chan_t channel;
    tlsd_pkg::byte_t data;
    logic            last;
  } payload_word_t;

  // parser model plus the queue of payload words still owed by the block
  class demux_scoreboard;
    tlsd_pkg::byte_t  tags [3];
    tlsd_pkg::phase_t parse_phase;
    tlsd_pkg::chan_t  channel;
    tlsd_pkg::len_t   remaining;
    payload_word_t    pending_payload [$];
    int               mismatches;

    function new();
      tags[0]     = tlsd_pkg::TAG_ZERO_RST;
      tags[1]     = tlsd_pkg::TAG_ONE_RST;
      tags[2]     = tlsd_pkg::TAG_TWO_RST;
      parse_phase = tlsd_pkg::PHASE_TAG;
      channel     = tlsd_pkg::CHAN_ZERO;
      remaining   = '0;
      mismatches  = 0;
    endfunction

    function void write_tag(tlsd_pkg::cfg_idx_t idx, tlsd_pkg::byte_t value);
      case (idx)
        tlsd_pkg::REG_TAG_ZERO: tags[0] = value;
        tlsd_pkg::REG_TAG_ONE:  tags[1] = value;
        tlsd_pkg::REG_TAG_TWO:  tags[2] = value;
        default: ;
      endcase
    endfunction

    function bit is_tag(tlsd_pkg::byte_t b);
      return (b == tags[0]) || (b == tags[1]) || (b == tags[2]);
    endfunction

    // advance the parser by one accepted input word
    function void note_byte(tlsd_pkg::byte_t b);
      payload_word_t w;
      case (parse_phase)
        tlsd_pkg::PHASE_TAG: begin
          // lowest channel wins when tags are equal
          if (b == tags[0]) begin
            channel = tlsd_pkg::CHAN_ZERO;
            parse_phase = tlsd_pkg::PHASE_LEN_HI;
          end else if (b == tags[1]) begin
            channel = tlsd_pkg::CHAN_ONE;
            parse_phase = tlsd_pkg::PHASE_LEN_HI;
          end else if (b == tags[2]) begin
            channel = tlsd_pkg::CHAN_TWO;
            parse_phase = tlsd_pkg::PHASE_LEN_HI;
          end
          remaining = '0;
        end
        tlsd_pkg::PHASE_LEN_HI: begin
          remaining = {b, 8'h00};
          parse_phase = tlsd_pkg::PHASE_LEN_LO;
        end
        tlsd_pkg::PHASE_LEN_LO: begin
          remaining = {remaining[15:8], b};
          parse_phase = (remaining == '0) ? tlsd_pkg::PHASE_TAG : tlsd_pkg::PHASE_DATA;
        end
        default: begin
          remaining = remaining - tlsd_pkg::len_t'(1);
          w.channel = channel;
          w.data    = b;
          w.last    = (remaining == '0);
          pending_payload.push_back(w);
          if (w.last) parse_phase = tlsd_pkg::PHASE_TAG;
        end
      endcase
    endfunction

    // compare one forwarded word against the oldest owed word
    function void check_word(tlsd_pkg::chan_t ch, tlsd_pkg::byte_t data, logic last);
      payload_word_t w;
      if (pending_payload.size() == 0) begin
        $error("unexpected word: channel %0d byte %0h last %0b", ch, data, last);
        mismatches++;
        return;
      end
      w = pending_payload.pop_front();
      if (ch !== w.channel) begin
        $error("out_channel: expected %0d, actual %0d", w.channel, ch);
        mismatches++;
      end
      if (data !== w.data) begin
        $error("out_byte: expected %0h, actual %0h", w.data, data);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("end_of_packet: expected %0b, actual %0b", w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  tlsd_pkg::cfg_idx_t cfg_index = tlsd_pkg::REG_TAG_ZERO;
  tlsd_pkg::byte_t    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tlsd_pkg::byte_t    in_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tlsd_pkg::chan_t    out_channel;
  tlsd_pkg::byte_t    out_byte;
  logic               end_of_packet;

  demux_scoreboard sb = new();
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int packet_words = 0;

  always #6 clk = ~clk;

  tagged_length_stream_demux u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .out_byte     (out_byte),
    .end_of_packet(end_of_packet)
  );

  // output side: random stall before each word
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = rx_stalls ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(out_channel, out_byte, end_of_packet);
  end

  task automatic write_reg(input tlsd_pkg::cfg_idx_t idx, input tlsd_pkg::byte_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_tag(idx, value);
  endtask

  task automatic write_tags(input tlsd_pkg::byte_t t0, input tlsd_pkg::byte_t t1,
                            input tlsd_pkg::byte_t t2);
    write_reg(tlsd_pkg::REG_TAG_ZERO, t0);
    write_reg(tlsd_pkg::REG_TAG_ONE, t1);
    write_reg(tlsd_pkg::REG_TAG_TWO, t2);
  endtask

  task automatic push_word(input tlsd_pkg::byte_t b);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  // idle word that matches no tag
  task automatic push_noise();
    tlsd_pkg::byte_t b;
    do b = tlsd_pkg::byte_t'($urandom_range(0, 255)); while (sb.is_tag(b));
    push_word(b);
  endtask

  task automatic send_packet(input tlsd_pkg::byte_t tag_b, input tlsd_pkg::len_t len);
    tlsd_pkg::byte_t b;
    push_word(tag_b);
    push_word(len[15:8]);
    push_word(len[7:0]);
    for (int i = 0; i < len; i++) begin
      // payload often carries tag values, which must pass through as data
      if ($urandom_range(0, 3) == 0) b = sb.tags[$urandom_range(0, 2)];
      else b = tlsd_pkg::byte_t'($urandom_range(0, 255));
      push_word(b);
    end
    packet_words += 3 + len;
  endtask

  // hold the sender until all owed words have left the block
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    tlsd_pkg::len_t len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default tags, skipped idle words, min and max byte values
    write_reg(REG_UNUSED, 8'h77);
    push_word(8'h77);
    push_word(8'h00);
    push_word(8'hff);
    push_word(tlsd_pkg::TAG_ZERO_RST);
    push_word(8'h00);
    push_word(8'h02);
    push_word(8'h00);
    push_word(8'hff);
    // zero length packet
    push_word(tlsd_pkg::TAG_ONE_RST);
    push_word(8'h00);
    push_word(8'h00);
    // payload equal to a tag
    push_word(tlsd_pkg::TAG_TWO_RST);
    push_word(8'h00);
    push_word(8'h01);
    push_word(tlsd_pkg::TAG_ZERO_RST);
    drain();

    // all tags equal: channel zero wins
    write_tags(8'h55, 8'h55, 8'h55);
    push_word(8'h55);
    push_word(8'h00);
    push_word(8'h01);
    push_word(8'haa);
    drain();

    // upper two tags equal: channel one wins
    write_tags(8'h10, 8'h20, 8'h20);
    push_word(8'h20);
    push_word(8'h00);
    push_word(8'h01);
    push_word(8'h5a);
    drain();

    // random packets over several tag settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: write_tags(tlsd_pkg::TAG_ZERO_RST, tlsd_pkg::TAG_ONE_RST, tlsd_pkg::TAG_TWO_RST);
        1: write_tags(8'h00, 8'hff, 8'h80);
        3: write_tags(8'hff, 8'hff, 8'h00);
        4: write_tags(8'h00, 8'h7f, 8'h00);
        default: write_tags(tlsd_pkg::byte_t'($urandom_range(0, 255)),
                            tlsd_pkg::byte_t'($urandom_range(0, 255)),
                            tlsd_pkg::byte_t'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, tlsd_pkg::byte_t'($urandom_range(0, 255)));
      tx_gaps   = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      rx_stalls = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      phase_start = packet_words;

      // long packets: full low length byte, and a nonzero high length byte
      if (p == 2) send_packet(sb.tags[$urandom_range(0, 2)], 16'h00ff);
      if (p == 4) send_packet(sb.tags[$urandom_range(0, 2)],
                              tlsd_pkg::len_t'(16'h0100 + $urandom_range(0, 40)));

      while (packet_words - phase_start < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) push_noise();
        end else begin
          len = ($urandom_range(0, 9) == 0) ? tlsd_pkg::len_t'(0)
                                            : tlsd_pkg::len_t'($urandom_range(1, 12));
          send_packet(sb.tags[$urandom_range(0, 2)], len);
        end
      end
      drain();
    end

    // final wait, bounded
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && sb.pending_payload.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_payload.size() != 0) begin
      $error("%0d payload words never arrived", sb.pending_payload.size());
      sb.mismatches++;
    end

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
sv/tlsd_pkg.sv
sv/tagged_length_stream_demux.sv
tb/tagged_length_stream_demux_tb.sv
